// ----- hdl/gjc_pkg.sv -----
`default_nettype none

package gjc_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int JDN_W    = 23;
    localparam int JREL_W   = 22;   // day count relative to March 1 of year zero
    localparam int CENT_W   = 7;
    localparam int YY_W     = 7;
    localparam int MTERM_W  = 9;
    localparam int MLEN_W   = 5;

    // Pipeline depth
    localparam int FWD_STG  = 6;
    localparam int BACK_STG = 13;
    localparam int NUM_STG  = FWD_STG + BACK_STG;

    // Request type codes
    localparam logic REQ_TO_JDN  = 1'b0;
    localparam logic REQ_TO_DATE = 1'b1;

    // Calendar constants
    localparam logic [JDN_W-1:0]  JDN_BASE      = 23'd1721119;
    localparam logic [JDN_W-1:0]  JDN_FIRST     = 23'd1721426;
    localparam logic [JDN_W-1:0]  JDN_LAST      = 23'd5373484;
    localparam logic [YEAR_W-1:0] YEAR_LAST     = 14'd9999;
    localparam logic [17:0]       DAYS_400Y     = 18'd146097;
    localparam logic [10:0]       DAYS_4Y       = 11'd1461;
    localparam logic [7:0]        MONTH_SPAN    = 8'd153;
    localparam logic [6:0]        YEARS_PER_CENT = 7'd100;

    // Reciprocals: floor(2**SH / divisor); the estimate is low by at most one
    localparam logic [7:0] RCP_100    = 8'd163;
    localparam int         RCP_100_SH = 14;
    localparam logic [6:0] RCP_400Y   = 7'd114;
    localparam int         RCP_400Y_SH = 24;
    localparam logic [7:0] RCP_4Y     = 8'd179;
    localparam int         RCP_4Y_SH  = 18;
    localparam logic [3:0] RCP_153    = 4'd13;
    localparam int         RCP_153_SH = 11;
    localparam logic [5:0] RCP_5      = 6'd51;
    localparam int         RCP_5_SH   = 8;

    typedef struct packed {
        logic               req_type;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [JDN_W-1:0]   day_number;
    } t_req;

    typedef struct packed {
        logic               req_type;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               bad;
        logic [JDN_W-1:0]   jdn;
    } t_tag;

    typedef struct packed {
        t_tag              tag;
        logic [JREL_W-1:0] jrel;
    } t_mid;

    typedef struct packed {
        logic [JDN_W-1:0]   jdn_out;
        logic [YEAR_W-1:0]  year_out;
        logic [MONTH_W-1:0] month_out;
        logic [DAY_W-1:0]   day_out;
        logic               valid_res;
        logic               leap;
        logic [MLEN_W-1:0]  month_length;
    } t_res;

    // Days from March 1 to the first of a March-based month: (153*m + 2) / 5
    function automatic logic [MTERM_W-1:0] march_days(input logic [MONTH_W-1:0] ma);
        logic [MTERM_W-1:0] r;
        case (ma)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
                                                    input logic lp);
        logic [MLEN_W-1:0] r;
        case (mo) inside
            4'd2:                     r = lp ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
            [4'd1:4'd12]:             r = 5'd31;
            default:                  r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gjc_req_if.sv -----
`default_nettype none

interface gjc_req_if;
    import gjc_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [JDN_W-1:0]   day_number;

    modport source (output valid, req_type, year, month, day, day_number, input ready);
    modport sink   (input valid, req_type, year, month, day, day_number, output ready);
endinterface

`default_nettype wire

// ----- hdl/gjc_res_if.sv -----
`default_nettype none

interface gjc_res_if;
    import gjc_pkg::*;

    logic               valid;
    logic               ready;
    logic [JDN_W-1:0]   jdn_out;
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;
    logic               valid_res;
    logic               leap;
    logic [MLEN_W-1:0]  month_length;

    modport source (output valid, jdn_out, year_out, month_out, day_out, valid_res, leap,
                    month_length, input ready);
    modport sink   (input valid, jdn_out, year_out, month_out, day_out, valid_res, leap,
                    month_length, output ready);
endinterface

`default_nettype wire

// ----- hdl/gregorian_jdn_converter_top.sv -----
// Gregorian date / Julian day number converter. Each request transaction carries either a
// date (req_type 0) or a day number (req_type 1) and yields exactly one result transaction,
// in order. The datapath is a 19-stage pipeline: six stages build the day number from the
// date, thirteen convert it back, each constant division done as a reciprocal multiply
// followed by a one-step correction. One transaction per cycle is taken as long as results
// are drained; every stage holds its own valid bit, so empty stages fill even while the
// output register waits on ready.
`default_nettype none

module gregorian_jdn_converter_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gjc_req_if.sink   i_req,
    gjc_res_if.source o_res
);
    import gjc_pkg::*;

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] w_en;
    t_req               w_req;
    t_mid               w_mid;
    t_res               w_res;

    // A stage advances when empty or when the stage after it advances
    always_comb begin
        w_en[NUM_STG-1] = !r_vld[NUM_STG-1] || o_res.ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_req.valid;
        end
        for (int k = 1; k < NUM_STG; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_req.req_type   = i_req.req_type;
    assign w_req.year       = i_req.year;
    assign w_req.month      = i_req.month;
    assign w_req.day        = i_req.day;
    assign w_req.day_number = i_req.day_number;

    gjc_date_to_day u_fwd (
        .i_clk (i_clk),
        .i_en  (w_en[FWD_STG-1:0]),
        .i_req (w_req),
        .o_mid (w_mid)
    );

    gjc_day_to_date u_back (
        .i_clk (i_clk),
        .i_en  (w_en[NUM_STG-1:FWD_STG]),
        .i_mid (w_mid),
        .o_res (w_res)
    );

    assign i_req.ready        = w_en[0];
    assign o_res.valid        = r_vld[NUM_STG-1];
    assign o_res.jdn_out      = w_res.jdn_out;
    assign o_res.year_out     = w_res.year_out;
    assign o_res.month_out    = w_res.month_out;
    assign o_res.day_out      = w_res.day_out;
    assign o_res.valid_res    = w_res.valid_res;
    assign o_res.leap         = w_res.leap;
    assign o_res.month_length = w_res.month_length;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_vld[0])
        else $error("accepted request did not enter the first stage");

    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (&r_vld) && !o_res.ready)
        else $error("request stalled while the pipeline has room");

    a_valid_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.valid_res |->
            o_res.month_out >= 4'd1 && o_res.month_out <= 4'd12 && o_res.month_length != '0)
        else $error("valid result with month out of range");

    a_valid_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.valid_res |->
            o_res.day_out != '0 && o_res.day_out <= o_res.month_length)
        else $error("valid result with day outside its month");

    a_leap_feb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.month_length == 5'd29 |-> o_res.leap && o_res.month_out == 4'd2)
        else $error("29-day month outside a leap February");

endmodule

`default_nettype wire

// ----- hdl/gjc_date_to_day.sv -----
`default_nettype none

module gjc_date_to_day (
    input  logic                        i_clk,
    input  logic [gjc_pkg::FWD_STG-1:0] i_en,
    input  gjc_pkg::t_req               i_req,
    output gjc_pkg::t_mid               o_mid
);
    import gjc_pkg::*;

    // Request fields and range flag ride along stage by stage
    t_req                r_req [FWD_STG-1];
    logic [FWD_STG-2:0]  r_bad;

    logic [MONTH_W-1:0]  r_s0_ma;
    logic [YEAR_W-1:0]   r_s0_ya;
    logic [MONTH_W-1:0]  r_s1_ma;
    logic [YEAR_W-1:0]   r_s1_ya;
    logic [21:0]         r_s1_pc;
    logic [MONTH_W-1:0]  r_s2_ma;
    logic [CENT_W-1:0]   r_s2_ce;
    logic [7:0]          r_s2_yr;
    logic [CENT_W-1:0]   r_s3_cent;
    logic [YY_W-1:0]     r_s3_yr;
    logic [MTERM_W-1:0]  r_s3_mterm;
    logic [MTERM_W-1:0]  r_s4_mterm;
    logic [15:0]         r_s4_ty;
    logic [21:0]         r_s4_tc;
    t_mid                r_mid;

    logic                n_s0_bad;
    logic [MONTH_W-1:0]  n_s0_ma;
    logic [YEAR_W-1:0]   n_s0_ya;
    logic [CENT_W-1:0]   n_s2_ce;
    logic [YEAR_W-1:0]   n_s2_yr;
    logic                n_s3_hi;
    logic [17:0]         n_s4_typ;
    logic [23:0]         n_s4_tcp;
    logic [JDN_W-1:0]    n_s5_sum;
    logic [JDN_W-1:0]    n_s5_jdn;
    logic [JDN_W-1:0]    n_s5_rel;

    always_comb begin
        if (i_req.req_type == REQ_TO_DATE) begin
            n_s0_bad = (i_req.day_number < JDN_FIRST) || (i_req.day_number > JDN_LAST);
        end else begin
            n_s0_bad = (i_req.year == '0) || (i_req.year > YEAR_LAST);
        end
        // Shift to a March-based year so the leap day falls at the end
        if (i_req.month > 4'd2) begin
            n_s0_ma = i_req.month - 4'd3;
            n_s0_ya = i_req.year;
        end else begin
            n_s0_ma = i_req.month + 4'd9;
            n_s0_ya = i_req.year - 14'd1;
        end
    end

    always_comb begin
        n_s2_ce = r_s1_pc[RCP_100_SH +: CENT_W];
        n_s2_yr = r_s1_ya - YEAR_W'(n_s2_ce) * YEAR_W'(YEARS_PER_CENT);
        n_s3_hi = r_s2_yr >= 8'(YEARS_PER_CENT);
        n_s4_typ = 18'(r_s3_yr) * 18'(DAYS_4Y);
        n_s4_tcp = 24'(r_s3_cent) * 24'(DAYS_400Y);
        n_s5_sum = JDN_W'(r_req[FWD_STG-2].day) + JDN_W'(r_s4_mterm)
                 + JDN_W'(r_s4_ty) + JDN_W'(r_s4_tc);
        if (r_req[FWD_STG-2].req_type == REQ_TO_DATE) begin
            n_s5_jdn = r_req[FWD_STG-2].day_number;
            n_s5_rel = r_req[FWD_STG-2].day_number - JDN_BASE;
        end else begin
            n_s5_jdn = n_s5_sum + JDN_BASE;
            n_s5_rel = n_s5_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_req[0] <= i_req;
            r_bad[0] <= n_s0_bad;
            r_s0_ma  <= n_s0_ma;
            r_s0_ya  <= n_s0_ya;
        end
        for (int k = 1; k < FWD_STG - 1; k++) begin
            if (i_en[k]) begin
                r_req[k] <= r_req[k-1];
                r_bad[k] <= r_bad[k-1];
            end
        end
        if (i_en[1]) begin
            r_s1_ma <= r_s0_ma;
            r_s1_ya <= r_s0_ya;
            r_s1_pc <= 22'(r_s0_ya) * 22'(RCP_100);
        end
        if (i_en[2]) begin
            r_s2_ma <= r_s1_ma;
            r_s2_ce <= n_s2_ce;
            r_s2_yr <= n_s2_yr[7:0];
        end
        if (i_en[3]) begin
            // Estimate may be one century short: correct it
            r_s3_cent  <= r_s2_ce + CENT_W'(n_s3_hi);
            r_s3_yr    <= n_s3_hi ? YY_W'(r_s2_yr - 8'(YEARS_PER_CENT)) : r_s2_yr[YY_W-1:0];
            r_s3_mterm <= march_days(r_s2_ma);
        end
        if (i_en[4]) begin
            r_s4_mterm <= r_s3_mterm;
            r_s4_ty    <= n_s4_typ[17:2];
            r_s4_tc    <= n_s4_tcp[23:2];
        end
        if (i_en[5]) begin
            r_mid.tag.req_type <= r_req[FWD_STG-2].req_type;
            r_mid.tag.year     <= r_req[FWD_STG-2].year;
            r_mid.tag.month    <= r_req[FWD_STG-2].month;
            r_mid.tag.day      <= r_req[FWD_STG-2].day;
            r_mid.tag.bad      <= r_bad[FWD_STG-2];
            r_mid.tag.jdn      <= n_s5_jdn;
            r_mid.jrel         <= n_s5_rel[JREL_W-1:0];
        end
    end

    assign o_mid = r_mid;

endmodule

`default_nettype wire

// ----- hdl/gjc_day_to_date.sv -----
`default_nettype none

module gjc_day_to_date (
    input  logic                         i_clk,
    input  logic [gjc_pkg::BACK_STG-1:0] i_en,
    input  gjc_pkg::t_mid                i_mid,
    output gjc_pkg::t_res                o_res
);
    import gjc_pkg::*;

    localparam logic [15:0] PM_MUL = 16'(5 * RCP_153);
    localparam logic [15:0] PM_OFS = 16'(3 * RCP_153);

    t_tag                r_tag [BACK_STG-1];

    logic [23:0]         r_b0_t;
    logic [23:0]         r_b1_t;
    logic [30:0]         r_b1_pt;
    logic [CENT_W-1:0]   r_b2_ce;
    logic [18:0]         r_b2_re;
    logic [CENT_W-1:0]   r_b3_cent;
    logic [17:0]         r_b3_t2;
    logic [CENT_W-1:0]   r_b4_cent;
    logic [17:0]         r_b4_t2;
    logic [25:0]         r_b4_py;
    logic [CENT_W-1:0]   r_b5_cent;
    logic [7:0]          r_b5_ye;
    logic [11:0]         r_b5_rd;
    logic [CENT_W-1:0]   r_b6_cent;
    logic [YY_W-1:0]     r_b6_yy;
    logic [8:0]          r_b6_d1;
    logic [CENT_W-1:0]   r_b7_cent;
    logic [YY_W-1:0]     r_b7_yy;
    logic [10:0]         r_b7_u;
    logic [14:0]         r_b7_pm;
    logic [CENT_W-1:0]   r_b8_cent;
    logic [YY_W-1:0]     r_b8_yy;
    logic [MONTH_W-1:0]  r_b8_me;
    logic [8:0]          r_b8_rm;
    logic [CENT_W-1:0]   r_b9_cent;
    logic [YY_W-1:0]     r_b9_yy;
    logic [MONTH_W-1:0]  r_b9_mm;
    logic [7:0]          r_b9_v;
    logic [13:0]         r_b10_pd;
    logic [7:0]          r_b10_v;
    logic [MONTH_W-1:0]  r_b10_mo;
    logic [CENT_W-1:0]   r_b10_c;
    logic [YY_W-1:0]     r_b10_y;
    logic [DAY_W-1:0]    r_b11_de;
    logic [3:0]          r_b11_rdd;
    logic [MONTH_W-1:0]  r_b11_mo;
    logic [YEAR_W-1:0]   r_b11_yo;
    logic                r_b11_leap;
    t_res                r_res;

    logic [CENT_W-1:0]   n_b2_ce;
    logic [24:0]         n_b2_re;
    logic                n_b3_hi;
    logic [18:0]         n_b3_rc;
    logic [7:0]          n_b5_ye;
    logic [18:0]         n_b5_rd;
    logic                n_b6_hi;
    logic [11:0]         n_b6_rdc;
    logic [11:0]         n_b6_sum;
    logic [11:0]         n_b7_u;
    logic [15:0]         n_b7_pm;
    logic [MONTH_W-1:0]  n_b8_me;
    logic [11:0]         n_b8_rm;
    logic                n_b9_hi;
    logic [8:0]          n_b9_rmc;
    logic                n_b10_inc;
    logic [MONTH_W-1:0]  n_b10_mo;
    logic [CENT_W-1:0]   n_b10_c;
    logic [YY_W-1:0]     n_b10_y;
    logic [DAY_W-1:0]    n_b11_de;
    logic [7:0]          n_b11_rdd;
    logic                n_b11_leap;
    logic [DAY_W-1:0]    n_b12_day;
    logic                n_b12_ok;

    always_comb begin
        n_b2_ce  = r_b1_pt[RCP_400Y_SH +: CENT_W];
        n_b2_re  = 25'(r_b1_t) - 25'(n_b2_ce) * 25'(DAYS_400Y);
        n_b3_hi  = r_b2_re >= 19'(DAYS_400Y);
        n_b3_rc  = n_b3_hi ? (r_b2_re - 19'(DAYS_400Y)) : r_b2_re;
        n_b5_ye  = r_b4_py[RCP_4Y_SH +: 8];
        n_b5_rd  = 19'(r_b4_t2) - 19'(n_b5_ye) * 19'(DAYS_4Y);
        n_b6_hi  = r_b5_rd >= 12'(DAYS_4Y);
        n_b6_rdc = n_b6_hi ? (r_b5_rd - 12'(DAYS_4Y)) : r_b5_rd;
        n_b6_sum = n_b6_rdc + 12'd4;
        // 5*d - 3 and its product with the reciprocal of 153, from d directly
        n_b7_u   = 12'(r_b6_d1) * 12'd5 - 12'd3;
        n_b7_pm  = 16'(r_b6_d1) * PM_MUL - PM_OFS;
        n_b8_me  = r_b7_pm[RCP_153_SH +: MONTH_W];
        n_b8_rm  = 12'(r_b7_u) - 12'(n_b8_me) * 12'(MONTH_SPAN);
        n_b9_hi  = r_b8_rm >= 9'(MONTH_SPAN);
        n_b9_rmc = n_b9_hi ? (r_b8_rm - 9'(MONTH_SPAN)) : r_b8_rm;
    end

    // Back to a January-based year; keep the year as century and year of century
    always_comb begin
        n_b10_inc = r_b9_mm >= 4'd10;
        n_b10_mo  = n_b10_inc ? (r_b9_mm - 4'd9) : (r_b9_mm + 4'd3);
        n_b10_c   = r_b9_cent;
        n_b10_y   = r_b9_yy;
        if (n_b10_inc) begin
            if (r_b9_yy == YY_W'(YEARS_PER_CENT - 7'd1)) begin
                n_b10_c = r_b9_cent + 7'd1;
                n_b10_y = '0;
            end else begin
                n_b10_y = r_b9_yy + 7'd1;
            end
        end
    end

    always_comb begin
        n_b11_de   = r_b10_pd[RCP_5_SH +: DAY_W];
        n_b11_rdd  = r_b10_v - 8'(n_b11_de) * 8'd5;
        n_b11_leap = (r_b10_y == '0) ? (r_b10_c[1:0] == 2'b00) : (r_b10_y[1:0] == 2'b00);
        n_b12_day  = r_b11_de + DAY_W'(r_b11_rdd >= 4'd5);
        if (r_tag[BACK_STG-2].req_type == REQ_TO_DATE) begin
            n_b12_ok = 1'b1;
        end else begin
            n_b12_ok = (r_b11_yo == r_tag[BACK_STG-2].year)
                    && (r_b11_mo == r_tag[BACK_STG-2].month)
                    && (n_b12_day == r_tag[BACK_STG-2].day);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_tag[0] <= i_mid.tag;
            r_b0_t   <= {i_mid.jrel, 2'b00} - 24'd1;
        end
        for (int k = 1; k < BACK_STG - 1; k++) begin
            if (i_en[k]) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
        if (i_en[1]) begin
            r_b1_t  <= r_b0_t;
            r_b1_pt <= 31'(r_b0_t) * 31'(RCP_400Y);
        end
        if (i_en[2]) begin
            r_b2_ce <= n_b2_ce;
            r_b2_re <= n_b2_re[18:0];
        end
        if (i_en[3]) begin
            r_b3_cent <= r_b2_ce + CENT_W'(n_b3_hi);
            r_b3_t2   <= n_b3_rc[17:0] | 18'd3;
        end
        if (i_en[4]) begin
            r_b4_cent <= r_b3_cent;
            r_b4_t2   <= r_b3_t2;
            r_b4_py   <= 26'(r_b3_t2) * 26'(RCP_4Y);
        end
        if (i_en[5]) begin
            r_b5_cent <= r_b4_cent;
            r_b5_ye   <= n_b5_ye;
            r_b5_rd   <= n_b5_rd[11:0];
        end
        if (i_en[6]) begin
            r_b6_cent <= r_b5_cent;
            r_b6_yy   <= YY_W'(r_b5_ye + 8'(n_b6_hi));
            r_b6_d1   <= n_b6_sum[10:2];
        end
        if (i_en[7]) begin
            r_b7_cent <= r_b6_cent;
            r_b7_yy   <= r_b6_yy;
            r_b7_u    <= n_b7_u[10:0];
            r_b7_pm   <= n_b7_pm[14:0];
        end
        if (i_en[8]) begin
            r_b8_cent <= r_b7_cent;
            r_b8_yy   <= r_b7_yy;
            r_b8_me   <= n_b8_me;
            r_b8_rm   <= n_b8_rm[8:0];
        end
        if (i_en[9]) begin
            r_b9_cent <= r_b8_cent;
            r_b9_yy   <= r_b8_yy;
            r_b9_mm   <= r_b8_me + MONTH_W'(n_b9_hi);
            r_b9_v    <= n_b9_rmc[7:0] + 8'd5;
        end
        if (i_en[10]) begin
            r_b10_pd <= 14'(r_b9_v) * 14'(RCP_5);
            r_b10_v  <= r_b9_v;
            r_b10_mo <= n_b10_mo;
            r_b10_c  <= n_b10_c;
            r_b10_y  <= n_b10_y;
        end
        if (i_en[11]) begin
            r_b11_de   <= n_b11_de;
            r_b11_rdd  <= n_b11_rdd[3:0];
            r_b11_mo   <= r_b10_mo;
            r_b11_yo   <= YEAR_W'(r_b10_c) * YEAR_W'(YEARS_PER_CENT) + YEAR_W'(r_b10_y);
            r_b11_leap <= n_b11_leap;
        end
        if (i_en[12]) begin
            if (r_tag[BACK_STG-2].bad) begin
                r_res <= '0;
            end else begin
                r_res.jdn_out      <= r_tag[BACK_STG-2].jdn;
                r_res.year_out     <= r_b11_yo;
                r_res.month_out    <= r_b11_mo;
                r_res.day_out      <= n_b12_day;
                r_res.valid_res    <= n_b12_ok;
                r_res.leap         <= r_b11_leap;
                r_res.month_length <= month_len(r_b11_mo, r_b11_leap);
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ----- test/gregorian_jdn_converter_top_tb.sv -----
`timescale 1ns / 1ps

module gregorian_jdn_converter_top_tb;
    import gjc_pkg::*;

    localparam int NUM_RANDOM  = 650;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 40;

    localparam longint unsigned MARCH_ONE_YEAR_ZERO = 1721119;
    localparam longint unsigned DAYS_IN_400_YEARS   = 146097;
    localparam longint unsigned DAYS_IN_4_YEARS     = 1461;

    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } t_directed_case;

    logic i_clk;
    logic i_rst_n;

    gjc_req_if req_bus ();
    gjc_res_if res_bus ();

    gregorian_jdn_converter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    t_res           staged_result;
    t_res           pending_conversions[$];
    t_directed_case calendar_cases[$];
    int             mismatches;
    int             burst_left;
    int             idle_cycles;
    logic [15:0]    drain_cycle;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_TO_JDN;
        req_bus.year = '0;
        req_bus.month = '0;
        req_bus.day = '0;
        req_bus.day_number = '0;
        res_bus.ready = 1'b0;
        staged_result = '0;
        mismatches = 0;
        burst_left = 0;
        drain_cycle = '0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit gregorian_leap(input longint unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic logic [MLEN_W-1:0] month_span(input longint unsigned m, input bit lp);
        int span[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12)
            return '0;
        if (lp && m == 2)
            return 5'd29;
        return MLEN_W'(span[m-1]);
    endfunction

    function automatic longint unsigned civil_to_day_number(input longint unsigned y,
                                                            input longint unsigned m,
                                                            input longint unsigned d);
        longint unsigned cent;
        // count months from March so the leap day falls at the end of the year
        if (m > 2) begin
            m = m - 3;
        end else begin
            m = m + 9;
            y = y - 1;
        end
        cent = y / 100;
        y = y - 100 * cent;
        return MARCH_ONE_YEAR_ZERO + d + (2 + 153 * m) / 5 + (DAYS_IN_4_YEARS * y) / 4
               + (DAYS_IN_400_YEARS * cent) / 4;
    endfunction

    function automatic void day_number_to_civil(input longint unsigned j,
                                                output longint unsigned y,
                                                output longint unsigned m,
                                                output longint unsigned d);
        longint unsigned t, cent, yy, dd, mm;
        j = j - MARCH_ONE_YEAR_ZERO;
        t = 4 * j - 1;
        cent = t / DAYS_IN_400_YEARS;
        t = t - DAYS_IN_400_YEARS * cent;
        dd = t / 4;
        t = 4 * dd + 3;
        yy = t / DAYS_IN_4_YEARS;
        dd = t - DAYS_IN_4_YEARS * yy;
        dd = (dd + 4) / 4;
        mm = (5 * dd - 3) / 153;
        dd = (5 * dd - 3) - 153 * mm;
        d = (dd + 5) / 5;
        y = 100 * cent + yy;
        if (mm < 10) begin
            m = mm + 3;
        end else begin
            m = mm - 9;
            y = y + 1;
        end
    endfunction

    function automatic t_res predict_conversion(input t_req r);
        t_res            res = '0;
        longint unsigned jdn, yo, mo, dout;
        bit              ok, lp;
        if (r.req_type == REQ_TO_JDN) begin
            if (r.year < 1 || r.year > YEAR_LAST)
                return res;
            jdn = civil_to_day_number(r.year, r.month, r.day);
            day_number_to_civil(jdn, yo, mo, dout);
            ok = (yo == r.year) && (mo == r.month) && (dout == r.day);
        end else begin
            if (r.day_number < JDN_FIRST || r.day_number > JDN_LAST)
                return res;
            jdn = r.day_number;
            day_number_to_civil(jdn, yo, mo, dout);
            ok = 1'b1;
        end
        lp = gregorian_leap(yo);
        res.jdn_out = jdn[JDN_W-1:0];
        res.year_out = yo[YEAR_W-1:0];
        res.month_out = mo[MONTH_W-1:0];
        res.day_out = dout[DAY_W-1:0];
        res.valid_res = ok;
        res.leap = lp;
        res.month_length = month_span(mo, lp);
        return res;
    endfunction

    task automatic add_case(input logic rt, input int y, input int m, input int d,
                            input int dn, input bit typed, input t_res want);
        t_directed_case c;
        c.req.req_type = rt;
        c.req.year = YEAR_W'(y);
        c.req.month = MONTH_W'(m);
        c.req.day = DAY_W'(d);
        c.req.day_number = JDN_W'(dn);
        c.typed = typed;
        c.want = want;
        calendar_cases.push_back(c);
    endtask

    task automatic send_item(input t_req r, input t_res want);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 15);
            if (gap > 0) begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        req_bus.valid <= 1'b1;
        req_bus.req_type <= r.req_type;
        req_bus.year <= r.year;
        req_bus.month <= r.month;
        req_bus.day <= r.day;
        req_bus.day_number <= r.day_number;
        staged_result <= want;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: cycle through always-ready, random, periodic and long-stall phases
    always @(posedge i_clk) begin
        drain_cycle <= drain_cycle + 16'd1;
        case (drain_cycle[8:7])
            2'd0:    res_bus.ready <= 1'b1;
            2'd1:    res_bus.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    res_bus.ready <= ((drain_cycle % 7) > 2);
            default: res_bus.ready <= (drain_cycle[4:0] < 5'd8);
        endcase
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_conversions.size() == 0) begin
                $display("%0t ns: result with none expected, jdn_out %0d", $time,
                         res_bus.jdn_out);
                mismatches++;
            end else begin
                want = pending_conversions.pop_front();
                report_field("jdn_out", 32'(want.jdn_out), 32'(res_bus.jdn_out));
                report_field("year_out", 32'(want.year_out), 32'(res_bus.year_out));
                report_field("month_out", 32'(want.month_out), 32'(res_bus.month_out));
                report_field("day_out", 32'(want.day_out), 32'(res_bus.day_out));
                report_field("valid_res", 32'(want.valid_res), 32'(res_bus.valid_res));
                report_field("leap", 32'(want.leap), 32'(res_bus.leap));
                report_field("month_length", 32'(want.month_length),
                             32'(res_bus.month_length));
            end
        end
        if (i_rst_n && req_bus.valid && req_bus.ready)
            pending_conversions.push_back(staged_result);
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("gregorian_jdn_converter_top: mismatch");
        $finish;
    end

    initial begin
        t_req r;
        int   pick;
        // range edges, out-of-range zeroing, normalization below year one
        add_case(REQ_TO_DATE, 0, 0, 0, 1721426, 1,
                 t_res'{23'd1721426, 14'd1, 4'd1, 5'd1, 1'b1, 1'b0, 5'd31});
        add_case(REQ_TO_DATE, 0, 0, 0, 5373484, 1,
                 t_res'{23'd5373484, 14'd9999, 4'd12, 5'd31, 1'b1, 1'b0, 5'd31});
        add_case(REQ_TO_DATE, 0, 0, 0, 1721425, 1, '0);
        add_case(REQ_TO_DATE, 0, 0, 0, 5373485, 1, '0);
        add_case(REQ_TO_DATE, 16383, 15, 31, 0, 1, '0);
        add_case(REQ_TO_DATE, 0, 0, 0, 23'h7FFFFF, 1, '0);
        add_case(REQ_TO_JDN, 1, 1, 1, 23'h7FFFFF, 1,
                 t_res'{23'd1721426, 14'd1, 4'd1, 5'd1, 1'b1, 1'b0, 5'd31});
        add_case(REQ_TO_JDN, 9999, 12, 31, 0, 1,
                 t_res'{23'd5373484, 14'd9999, 4'd12, 5'd31, 1'b1, 1'b0, 5'd31});
        add_case(REQ_TO_JDN, 0, 1, 1, 2451545, 1, '0);
        add_case(REQ_TO_JDN, 10000, 1, 1, 0, 1, '0);
        add_case(REQ_TO_JDN, 16383, 15, 31, 23'h7FFFFF, 1, '0);
        add_case(REQ_TO_JDN, 1, 1, 0, 0, 1,
                 t_res'{23'd1721425, 14'd0, 4'd12, 5'd31, 1'b0, 1'b1, 5'd31});
        // leap days, bad months and days, rollover past the last year
        add_case(REQ_TO_JDN, 2000, 2, 29, 0, 0, '0);
        add_case(REQ_TO_JDN, 1900, 2, 29, 0, 0, '0);
        add_case(REQ_TO_JDN, 2023, 2, 29, 0, 0, '0);
        add_case(REQ_TO_JDN, 2020, 0, 15, 0, 0, '0);
        add_case(REQ_TO_JDN, 2020, 13, 1, 0, 0, '0);
        add_case(REQ_TO_JDN, 9999, 15, 31, 0, 0, '0);
        add_case(REQ_TO_JDN, 9999, 13, 31, 0, 0, '0);
        add_case(REQ_TO_JDN, 1987, 4, 31, 0, 0, '0);
        add_case(REQ_TO_JDN, 1600, 7, 0, 0, 0, '0);
        add_case(REQ_TO_JDN, 2024, 12, 31, 0, 0, '0);
        add_case(REQ_TO_DATE, 0, 0, 0, 2451545, 0, '0);
        add_case(REQ_TO_DATE, 0, 0, 0, 2460000, 0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (calendar_cases[k])
            send_item(calendar_cases[k].req, calendar_cases[k].typed
                      ? calendar_cases[k].want : predict_conversion(calendar_cases[k].req));

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // unused fields carry noise
            r.year = YEAR_W'($urandom);
            r.month = MONTH_W'($urandom);
            r.day = DAY_W'($urandom);
            r.day_number = JDN_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                r.req_type = REQ_TO_JDN;
                if (pick < 52)
                    r.year = YEAR_W'($urandom_range(1, 9999));
                if (pick < 40) begin
                    r.month = MONTH_W'($urandom_range(1, 12));
                    r.day = DAY_W'($urandom_range(1,
                                   month_span(r.month, gregorian_leap(r.year))));
                end
            end else begin
                r.req_type = REQ_TO_DATE;
                if (pick < 88)
                    r.day_number = JDN_W'($urandom_range(JDN_FIRST, JDN_LAST));
                else if (pick < 91)
                    r.day_number = JDN_W'($urandom_range(JDN_FIRST - 40, JDN_FIRST + 40));
                else if (pick < 94)
                    r.day_number = JDN_W'($urandom_range(JDN_LAST - 40, JDN_LAST + 40));
            end
            send_item(r, predict_conversion(r));
        end

        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_conversions.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("gregorian_jdn_converter_top: match");
        else
            $display("gregorian_jdn_converter_top: mismatch");
        $finish;
    end

endmodule
